// ----- rtl/gki_pkg.sv -----
package gki_pkg;
  localparam int GRIPS = 8;
  localparam int STEPS = 8;
  localparam int FINGERS = 5;
  localparam int POS_BITS = 10;
  localparam int GRIP_W = 3;
  localparam int STEP_W = 3;
  localparam int FING_W = 3;
  localparam int CNT_W = 7;
  localparam int PROD_W = POS_BITS + CNT_W;
  localparam int ROW_AW = GRIP_W + STEP_W;
  localparam int TGT_AW = $clog2(GRIPS * STEPS * FINGERS);
  localparam int CFG_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd100;
  localparam logic [CNT_W-1:0] CNT_HALF = 7'd50;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_TARGET = 1'b1;
  localparam logic [0:0] REG_GRIP = 1'd0;
  localparam logic [0:0] REG_SPEED = 1'd1;

  typedef struct packed {
    logic [POS_BITS-1:0] value;
    logic                blank;
  } target_t;

  typedef struct packed {
    logic                    go;
    logic [PROD_W-1:0]       num;
    logic [CNT_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [PROD_W-1:0]       quo;
  } div_rsp_t;
endpackage

// ----- rtl/gki_divider.sv -----
module gki_divider
  import gki_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CW = $clog2(PROD_W + 1);

  logic [CNT_W:0] rem;
  logic [PROD_W-1:0] quo;
  logic [CNT_W-1:0] den;
  logic [CW-1:0] cnt;
  logic busy;
  logic done;
  logic [CNT_W:0] shifted;

  assign shifted = {rem[CNT_W-1:0], quo[PROD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt <= CW'(PROD_W);
        rem <= '0;
        quo <= req.num;
        den <= req.den;
      end else if (busy) begin
        if (shifted >= {1'b0, den}) begin
          rem <= shifted - {1'b0, den};
          quo <= {quo[PROD_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[PROD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;
endmodule

// ----- rtl/grip_keyframe_interpolator_unit.sv -----
// Keyframe interpolator. Write beats load row counts and finger targets and give no
// result. An evaluate beat scans the active grip's row pairs, reading each row count
// and comparing it with the previous one, up to the matching pair, or to the last pair
// when no pair holds the position, which gives one result with segment_found low. Each
// finger then fetches both targets, skipping blank rows, fetches both counts and runs
// the 17-step serial divider, which is skipped when the two counts are equal.
// busy is high throughout; results appear as single-cycle strobe pulses
// on valid and cannot be stalled, so the receiver must take each one as it appears.
module grip_keyframe_interpolator_unit
  import gki_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                operation,
  input  logic [GRIP_W-1:0]   grip_slot,
  input  logic [STEP_W-1:0]   step_row,
  input  logic                entry_kind,
  input  logic [FING_W-1:0]   finger_slot,
  input  logic [9:0]          entry_value,
  input  logic                entry_blank,
  input  logic [6:0]          grip_position,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                valid,
  output logic [FING_W-1:0]   finger_index,
  output logic [POS_BITS-1:0] finger_position,
  output logic [7:0]          speed_out,
  output logic                direction,
  output logic                segment_found,
  output logic                table_fault,
  output logic                last
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_ARD = 4'd3;
  localparam logic [3:0] S_ACHK = 4'd4;
  localparam logic [3:0] S_BRD = 4'd5;
  localparam logic [3:0] S_BCHK = 4'd6;
  localparam logic [3:0] S_CRD = 4'd7;
  localparam logic [3:0] S_CA = 4'd8;
  localparam logic [3:0] S_CB = 4'd9;
  localparam logic [3:0] S_DIV = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;

  logic [CNT_W-1:0] row_mem [GRIPS*STEPS];
  target_t tgt_mem [GRIPS*STEPS*FINGERS];
  logic [CNT_W-1:0] row_q;
  target_t tgt_q;
  logic [ROW_AW-1:0] row_ra;
  logic [TGT_AW-1:0] tgt_ra;

  logic [3:0] state;
  logic [GRIP_W-1:0] grip, cur_grip;
  logic [7:0] speed;
  logic [CNT_W-1:0] pos, prev_cnt;
  logic [STEP_W:0] scan, seg;
  logic [STEP_W:0] ra, rb;
  logic [FING_W-1:0] fing;
  logic [POS_BITS-1:0] pa, pb;
  logic [CNT_W-1:0] ca;
  logic neg;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [CNT_W-1:0] wcnt;
  assign wcnt = (entry_value > 10'(CNT_MAX)) ? CNT_MAX : entry_value[CNT_W-1:0];

  logic wr_go;
  assign wr_go = start && !busy && operation == OP_WRITE
                 && {1'b0, grip_slot} < (GRIP_W+1)'(GRIPS)
                 && {1'b0, step_row} < (STEP_W+1)'(STEPS);

  function automatic logic [TGT_AW-1:0] tix(logic [GRIP_W-1:0] g, logic [STEP_W-1:0] s,
                                            logic [FING_W-1:0] f);
    return TGT_AW'((TGT_AW'(g) * TGT_AW'(STEPS) + TGT_AW'(s)) * TGT_AW'(FINGERS)
                   + TGT_AW'(f));
  endfunction

  always_ff @(posedge clk) begin
    if (wr_go && entry_kind == KIND_COUNT)
      row_mem[{grip_slot, step_row}] <= wcnt;
    if (wr_go && entry_kind == KIND_TARGET && finger_slot < FING_W'(FINGERS))
      tgt_mem[tix(grip_slot, step_row, finger_slot)] <= '{entry_value, entry_blank};
    row_q <= row_mem[row_ra];
    tgt_q <= tgt_mem[tgt_ra];
  end

  // read address select
  always_comb begin
    row_ra = {cur_grip, scan[STEP_W-1:0]};
    tgt_ra = tix(cur_grip, ra[STEP_W-1:0], fing);
    unique case (state)
      S_BRD, S_BCHK: tgt_ra = tix(cur_grip, rb[STEP_W-1:0], fing);
      S_CRD: begin
        row_ra = {cur_grip, ra[STEP_W-1:0]};
        tgt_ra = tix(cur_grip, rb[STEP_W-1:0], fing);
      end
      S_CA: row_ra = {cur_grip, rb[STEP_W-1:0]};
      default: ;
    endcase
  end

  // interpolation numerator, magnitudes only
  logic [POS_BITS:0] dmag;
  logic [CNT_W-1:0] pd;
  logic [PROD_W-1:0] prod;
  assign pd = (pos >= ca) ? pos - ca : ca - pos;
  assign prod = PROD_W'(dmag) * PROD_W'(pd);

  gki_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [PROD_W:0] res;
  assign res = neg ? (PROD_W+1)'(pa) - (PROD_W+1)'(drsp.quo)
                   : (PROD_W+1)'(pa) + (PROD_W+1)'(drsp.quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grip <= '0;
      speed <= 8'd255;
      valid <= 1'b0;
      dreq.go <= 1'b0;
    end else begin
      valid <= 1'b0;
      dreq.go <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_GRIP) grip <= cfg_data[GRIP_W-1:0];
        else speed <= cfg_data;
      end
      unique case (state)
        S_IDLE: if (start && operation == OP_EVAL) begin
          pos <= (grip_position > CNT_MAX) ? CNT_MAX : grip_position;
          cur_grip <= grip;
          speed_out <= speed;
          direction <= ((grip_position > CNT_MAX) ? CNT_MAX : grip_position) > CNT_HALF;
          scan <= '0;
          state <= S_SRD;
        end
        S_SRD: begin
          if (scan != '0) begin
            if (pos >= prev_cnt && pos <= row_q) begin
              seg <= scan - 1'b1;
              ra <= scan - 1'b1;
              rb <= scan;
              fing <= '0;
              state <= S_ARD;
            end else if (scan == (STEP_W+1)'(STEPS-1)) begin
              finger_index <= '0; finger_position <= '0; segment_found <= 1'b0;
              table_fault <= 1'b0; last <= 1'b1; valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              scan <= scan + 1'b1;
              state <= S_SCMP;
            end
          end else begin
            scan <= scan + 1'b1;
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          prev_cnt <= row_q;
          state <= S_SRD;
        end
        S_ARD: state <= S_ACHK;
        S_ACHK: if (tgt_q.blank) begin
          if (ra == '0) begin
            finger_position <= '0; table_fault <= 1'b1; state <= S_OUT;
          end else begin
            ra <= ra - 1'b1; state <= S_ARD;
          end
        end else begin
          pa <= tgt_q.value; state <= S_BRD;
        end
        S_BRD: state <= S_BCHK;
        S_BCHK: if (tgt_q.blank) begin
          if (rb == (STEP_W+1)'(STEPS-1)) begin
            finger_position <= '0; table_fault <= 1'b1; state <= S_OUT;
          end else begin
            rb <= rb + 1'b1; state <= S_BRD;
          end
        end else begin
          pb <= tgt_q.value; state <= S_CRD;
        end
        S_CRD: state <= S_CA;
        S_CA: begin
          ca <= row_q;
          neg <= (pb < pa) ^ (pos < row_q);
          dmag <= (pb < pa) ? (POS_BITS+1)'(pa - pb) : (POS_BITS+1)'(pb - pa);
          state <= S_CB;
        end
        S_CB: begin
          dreq.den <= (row_q >= ca) ? row_q - ca : ca - row_q;
          dreq.num <= prod;
          neg <= neg ^ (row_q < ca);
          table_fault <= 1'b0;
          if (row_q == ca) begin
            finger_position <= pa; state <= S_OUT;
          end else begin
            dreq.go <= 1'b1; state <= S_DIV;
          end
        end
        S_DIV: if (drsp.done) begin
          if (res[PROD_W]) finger_position <= '0;
          else if (res[PROD_W-1:POS_BITS] != '0) finger_position <= POS_MAX;
          else finger_position <= res[POS_BITS-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          valid <= 1'b1;
          finger_index <= fing;
          segment_found <= 1'b1;
          last <= fing == FING_W'(FINGERS-1);
          if (fing == FING_W'(FINGERS-1)) state <= S_IDLE;
          else begin
            fing <= fing + 1'b1;
            ra <= seg; rb <= seg + 1'b1;
            state <= S_ARD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;
endmodule

// ----- rtl/gki_checker.sv -----
module gki_checker
  import gki_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic busy,
  input logic valid,
  input logic last,
  input logic segment_found,
  input logic table_fault,
  input logic [FING_W-1:0] finger_index
);
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst) valid |-> $past(busy))
    else $error("result while idle");
  a_fault_seg: assert property (@(posedge clk) disable iff (rst)
    valid && table_fault |-> segment_found) else $error("fault without segment");
  a_noseg_last: assert property (@(posedge clk) disable iff (rst)
    valid && !segment_found |-> last && finger_index == '0) else $error("bad no-segment beat");
  a_last_idle: assert property (@(posedge clk) disable iff (rst) valid && last |-> !busy)
    else $error("busy after last");
endmodule

bind grip_keyframe_interpolator_unit gki_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .valid(valid), .last(last),
  .segment_found(segment_found), .table_fault(table_fault), .finger_index(finger_index)
);

// ----- tb/sv/grip_keyframe_interpolator_unit_tb.sv -----
module grip_keyframe_interpolator_unit_tb;
  import gki_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                op;
    logic [GRIP_W-1:0]   grip;
    logic [STEP_W-1:0]   row;
    logic                kind;
    logic [FING_W-1:0]   finger;
    logic [9:0]          value;
    logic                blank;
    logic [6:0]          pos;
  } beat_t;

  typedef struct packed {
    logic [FING_W-1:0]   finger;
    logic [POS_BITS-1:0] position;
    logic [7:0]          speed;
    logic                dir;
    logic                found;
    logic                fault;
    logic                last;
  } finger_cmd_t;

  class keyframe_scoreboard;
    int unsigned          counts[GRIPS*STEPS];
    bit                   count_set[GRIPS*STEPS];
    int unsigned          targets[GRIPS*STEPS*FINGERS];
    bit                   blanks[GRIPS*STEPS*FINGERS];
    bit                   target_set[GRIPS*STEPS*FINGERS];
    int unsigned          grip_sel;
    int unsigned          speed;
    finger_cmd_t          expected_cmds[$];
    int                   errors;

    function void clear();
      foreach (count_set[i]) count_set[i] = 0;
      foreach (target_set[i]) target_set[i] = 0;
      grip_sel = 0;
      speed = 255;
      errors = 0;
    endfunction

    function void set_reg(bit idx, int unsigned data);
      if (idx == REG_GRIP) grip_sel = data % GRIPS;
      else speed = data & 8'hff;
    endfunction

    function int unsigned tix(int unsigned g, int unsigned s, int unsigned f);
      return (g * STEPS + s) * FINGERS + f;
    endfunction

    // works out the finger commands of one evaluation; ok is 0 when an unwritten entry is read
    function bit interpolate(int unsigned raw_pos, ref finger_cmd_t cmds[$]);
      int unsigned p, g, seg;
      int ra, rb, pa, pb, ca, cb, res;
      bit ok, fault;
      finger_cmd_t c;
      p = (raw_pos > CNT_MAX) ? CNT_MAX : raw_pos;
      g = grip_sel;
      ok = 1;
      seg = STEPS;
      cmds.delete();
      for (int r = 0; r + 1 < STEPS; r++) begin
        if (!count_set[g*STEPS+r] || !count_set[g*STEPS+r+1]) ok = 0;
        if (p >= counts[g*STEPS+r] && p <= counts[g*STEPS+r+1]) begin
          seg = r;
          break;
        end
      end
      c = '0;
      c.speed = speed;
      c.dir = (p > CNT_HALF);
      if (seg == STEPS) begin
        c.last = 1;
        cmds.push_back(c);
        return ok;
      end
      for (int f = 0; f < FINGERS; f++) begin
        ra = seg;
        rb = seg + 1;
        res = 0;
        while (ra >= 0) begin
          if (!target_set[tix(g, ra, f)]) ok = 0;
          if (!blanks[tix(g, ra, f)]) break;
          ra--;
        end
        while (rb < STEPS) begin
          if (!target_set[tix(g, rb, f)]) ok = 0;
          if (!blanks[tix(g, rb, f)]) break;
          rb++;
        end
        fault = (ra < 0 || rb >= STEPS);
        if (!fault) begin
          if (!count_set[g*STEPS+ra] || !count_set[g*STEPS+rb]) ok = 0;
          pa = targets[tix(g, ra, f)];
          pb = targets[tix(g, rb, f)];
          ca = counts[g*STEPS+ra];
          cb = counts[g*STEPS+rb];
          if (cb == ca) res = pa;
          else res = pa + (int'(p) - ca) * (pb - pa) / (cb - ca);
          if (res < 0) res = 0;
          if (res > POS_MAX) res = POS_MAX;
        end
        c.finger = f;
        c.position = res;
        c.found = 1;
        c.fault = fault;
        c.last = (f == FINGERS - 1);
        cmds.push_back(c);
      end
      return ok;
    endfunction

    function bit eval_safe(int unsigned raw_pos);
      finger_cmd_t tmp[$];
      return interpolate(raw_pos, tmp);
    endfunction

    function void note_beat(beat_t b);
      finger_cmd_t cmds[$];
      int unsigned k;
      if (b.op == OP_WRITE) begin
        if (b.grip >= GRIPS || b.row >= STEPS) return;
        k = b.grip * STEPS + b.row;
        if (b.kind == KIND_COUNT) begin
          counts[k] = (b.value > CNT_MAX) ? CNT_MAX : b.value;
          count_set[k] = 1;
        end else if (b.finger < FINGERS) begin
          targets[tix(b.grip, b.row, b.finger)] = b.value & POS_MAX;
          blanks[tix(b.grip, b.row, b.finger)] = b.blank;
          target_set[tix(b.grip, b.row, b.finger)] = 1;
        end
        return;
      end
      void'(interpolate(b.pos, cmds));
      foreach (cmds[i]) expected_cmds.push_back(cmds[i]);
    endfunction

    function void check_beat(finger_cmd_t got);
      finger_cmd_t want;
      if (expected_cmds.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $realtime, got);
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      if (got.finger !== want.finger || got.position !== want.position ||
          got.speed !== want.speed || got.dir !== want.dir ||
          got.found !== want.found || got.fault !== want.fault ||
          got.last !== want.last) begin
        $display("%0t mismatch: expected %p, actual %p", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                operation;
  logic [GRIP_W-1:0]   grip_slot;
  logic [STEP_W-1:0]   step_row;
  logic                entry_kind;
  logic [FING_W-1:0]   finger_slot;
  logic [9:0]          entry_value;
  logic                entry_blank;
  logic [6:0]          grip_position;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                valid;
  logic [FING_W-1:0]   finger_index;
  logic [POS_BITS-1:0] finger_position;
  logic [7:0]          speed_out;
  logic                direction;
  logic                segment_found;
  logic                table_fault;
  logic                last;

  keyframe_scoreboard sb;
  int                 beats_sent;
  bit                 lull_off;
  int                 quiet_cycles;

  grip_keyframe_interpolator_unit uut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && valid)
      sb.check_beat({finger_index, finger_position, speed_out, direction,
                     segment_found, table_fault, last});
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(beat_t b);
    if (!lull_off && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    while (busy) @(negedge clk);
    start <= 1;
    {operation, grip_slot, step_row, entry_kind, finger_slot,
     entry_value, entry_blank, grip_position} <= b;
    @(posedge clk);
    sb.note_beat(b);
    beats_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    start <= 0;
    while (sb.expected_cmds.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, int unsigned data);
    go_idle();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic write_count(int g, int r, int v);
    beat_t b;
    b = '0;
    b.op = OP_WRITE;
    b.grip = g;
    b.row = r;
    b.kind = KIND_COUNT;
    b.value = v;
    b.blank = $urandom_range(0, 1);
    b.pos = $urandom;
    send(b);
  endtask

  task automatic write_target(int g, int r, int f, int v, bit blank);
    beat_t b;
    b = '0;
    b.op = OP_WRITE;
    b.grip = g;
    b.row = r;
    b.kind = KIND_TARGET;
    b.finger = f;
    b.value = v;
    b.blank = blank;
    b.pos = $urandom;
    send(b);
  endtask

  task automatic evaluate(int p);
    beat_t b;
    b = $urandom;
    b.op = OP_EVAL;
    b.pos = p;
    send(b);
  endtask

  task automatic load_random_grip(int g);
    int c[STEPS];
    int t;
    bit sorted;
    sorted = $urandom_range(0, 3) != 0;
    foreach (c[i]) c[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 100);
    if (sorted) begin
      for (int i = 1; i < STEPS; i++)
        for (int j = i; j > 0 && c[j-1] > c[j]; j--) begin
          t = c[j];
          c[j] = c[j-1];
          c[j-1] = t;
        end
    end
    for (int r = 0; r < STEPS; r++) begin
      write_count(g, r, c[r]);
      for (int f = 0; f < FINGERS; f++)
        write_target(g, r, f, $urandom_range(0, 1023), $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    int dir_counts[STEPS];
    int dir_pos[10];
    int g, p, n;
    dir_counts = '{5, 5, 30, 50, 70, 90, 100, 1023};
    dir_pos = '{0, 5, 17, 30, 50, 51, 64, 99, 100, 127};
    sb = new();
    sb.clear();
    beats_sent = 0;
    lull_off = 0;
    rst = 1;
    start = 0;
    {operation, grip_slot, step_row, entry_kind, finger_slot,
     entry_value, entry_blank, grip_position} = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // hand-built table: extremes, equal counts, blank skips and edge faults
    for (int r = 0; r < STEPS; r++) begin
      write_count(0, r, dir_counts[r]);
      write_target(0, r, 0, (r == STEPS - 1) ? 1023 : r * 140, 0);
      write_target(0, r, 1, 1023 - r * 100, r == 0);
      write_target(0, r, 2, r * 90, r >= 5);
      write_target(0, r, 3, 900 - r * 30, r == 2 || r == 3);
      write_target(0, r, 4, 1023 - r * 120, r == 4);
    end
    write_target(0, 3, 7, 1023, 1);
    foreach (dir_pos[i]) evaluate(dir_pos[i]);
    write_reg(REG_SPEED, 0);
    write_reg(REG_GRIP, 0);
    evaluate(51);
    evaluate(100);

    while (beats_sent < 500) begin
      if (beats_sent > 420) lull_off = 1;
      g = $urandom_range(0, GRIPS - 1);
      write_reg(REG_GRIP, g);
      n = $urandom_range(0, 3);
      write_reg(REG_SPEED, (n == 0) ? 0 : (n == 1) ? 255 : $urandom_range(0, 255));
      load_random_grip(g);
      if ($urandom_range(0, 1)) write_count($urandom_range(0, GRIPS - 1), 0, 0);
      write_target(g, $urandom_range(0, STEPS - 1), $urandom_range(FINGERS, 7),
                   $urandom_range(0, 1023), $urandom_range(0, 1));
      repeat ($urandom_range(8, 14)) begin
        p = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
        if (sb.eval_safe(p)) evaluate(p);
      end
    end

    go_idle();
    repeat (200) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
